/* src/fpba_pkg.sv */
// Shared types and constants for the free page bitmap allocator.
// No dependencies; imported by fpba_word_unit and the top level.
`timescale 1ns / 1ps
`default_nettype none

package fpba_pkg;

  localparam int TRACKED_PAGES_DEF = 4096;
  localparam int WORD_BITS_DEF     = 32;

  // configuration port: byte address, one 32-bit register at offset 0
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_FIRST_TRACKED_PAGE = 1'b0;

  typedef enum logic [1:0] {
    MODE_QUERY     = 2'd0,
    MODE_MARK_OCC  = 2'd1,
    MODE_MARK_FREE = 2'd2,
    MODE_FIND      = 2'd3
  } mode_t;

  typedef enum logic {
    WOP_SET   = 1'b0,
    WOP_CLEAR = 1'b1
  } word_op_t;

  // control into the shared word unit
  typedef struct packed {
    word_op_t op;
    logic     tail;   // word is the last one: bits past the window count as occupied
  } word_ctl_t;

  // status out of the shared word unit
  typedef struct packed {
    logic bit_val;
    logic has_free;
  } word_stat_t;

endpackage : fpba_pkg

`default_nettype wire

/* src/fpba_if.sv */
// Valid/ready channel interfaces for request and result transactions.
// Depends on nothing; used by the top level ports.
`timescale 1ns / 1ps
`default_nettype none

interface fpba_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] page_id;

  modport source (output valid, output mode, output page_id, input ready);
  modport sink   (input valid, input mode, input page_id, output ready);
endinterface : fpba_req_if

interface fpba_res_if;
  logic        valid;
  logic        ready;
  logic        occupied;
  logic        found;
  logic [31:0] free_page_id;
  logic        out_of_range;

  modport source (output valid, output occupied, output found, output free_page_id,
                  output out_of_range, input ready);
  modport sink   (input valid, input occupied, input found, input free_page_id,
                  input out_of_range, output ready);
endinterface : fpba_res_if

`default_nettype wire

/* src/fpba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fpba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : fpba_ram

`default_nettype wire

/* src/fpba_word_unit.sv */
// Shared bitmap word unit: bit test, bit set/clear and first-free search.
// Depends on fpba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpba_word_unit #(
  parameter int WORD_BITS = 32,
  parameter int LAST_BITS = 32,
  parameter int BW        = $clog2(WORD_BITS)
) (
  input  fpba_pkg::word_ctl_t  ctl,
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [BW-1:0]        bit_i,
  output logic [WORD_BITS-1:0] word_o,
  output logic [BW-1:0]        free_bit_o,
  output fpba_pkg::word_stat_t stat
);
  import fpba_pkg::*;

  logic [WORD_BITS-1:0] onehot;
  logic [WORD_BITS-1:0] eff;

  assign onehot = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_i;
  assign word_o = (ctl.op == WOP_SET) ? (word_i | onehot) : (word_i & ~onehot);

  always_comb begin
    eff = word_i;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (ctl.tail && (j >= LAST_BITS)) begin
        eff[j] = 1'b1;
      end
    end
  end

  // lowest clear bit wins
  always_comb begin
    free_bit_o = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (!eff[j]) begin
        free_bit_o = BW'(j);
      end
    end
  end

  assign stat.bit_val  = |(word_i & onehot);
  assign stat.has_free = ~&eff;

endmodule : fpba_word_unit

`default_nettype wire

/* src/free_page_bitmap_allocator.sv */
// Free page bitmap allocator top level: sequencer, config register, output register.
// Depends on fpba_pkg, fpba_if, fpba_ram and fpba_word_unit.
//
//   channel   dir   handshake           payload
//   in_req    in    valid/ready         mode, page_id
//   out_res   out   valid/ready         occupied, found, free_page_id, out_of_range
//   cfg_*     in    APB write/read      first_tracked_page at byte 0
//
// Query and mark: from accept to the result register through offset divide, read and modify.
// Find: bitmap words are read from word 0 up, one bitmap word read per cycle, until the word
// holding the first free page, or up to the last word when none is free.
// After reset a clearing pass writes every bitmap word, with in_req not ready.
// A new request is taken while a result still waits; a finished item holds until out_res frees.
`timescale 1ns / 1ps
`default_nettype none

module free_page_bitmap_allocator #(
  parameter int TRACKED_PAGES = fpba_pkg::TRACKED_PAGES_DEF,
  parameter int WORD_BITS     = fpba_pkg::WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  fpba_req_if.sink                        in_req,
  fpba_res_if.source                      out_res,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [fpba_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  import fpba_pkg::*;

  localparam int NUM_WORDS = (TRACKED_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int LAST_WORD = NUM_WORDS - 1;
  localparam int LAST_BITS = TRACKED_PAGES - LAST_WORD * WORD_BITS;
  localparam int RW        = $clog2(TRACKED_PAGES);
  localparam int BW        = $clog2(WORD_BITS);
  localparam int PW        = RW + 8;
  localparam logic [32:0] RECIP =
    33'(((64'd1 << 32) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_DIV   = 8'b0000_0100,
    ST_READ  = 8'b0000_1000,
    ST_MOD   = 8'b0001_0000,
    ST_SCAN  = 8'b0010_0000,
    ST_FIN   = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0]    base_r;
  mode_t          mode_r, mode_nxt;
  logic [RW-1:0]  rel_r, rel_nxt;
  logic           inwin_r, inwin_nxt;
  logic [WAW-1:0] q_r, q_nxt;
  logic [BW-1:0]  bit_r, bit_nxt;
  logic [WAW-1:0] clr_addr_r, clr_addr_nxt;
  logic [WAW:0]   scan_addr_r, scan_addr_nxt;
  logic           chk_v_r, chk_v_nxt;
  logic [WAW-1:0] chk_idx_r, chk_idx_nxt;
  logic [WAW-1:0] fidx_r, fidx_nxt;
  logic [BW-1:0]  fbit_r, fbit_nxt;
  logic           res_occ_r, res_occ_nxt;
  logic           res_fnd_r, res_fnd_nxt;
  logic [31:0]    res_fid_r, res_fid_nxt;
  logic           res_oor_r, res_oor_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_occ_r, out_fnd_r, out_oor_r;
  logic [31:0]    out_fid_r;

  logic [32:0]    diff;
  logic [RW+32:0] prod;
  logic [PW-1:0]  qwb;
  logic [RW-1:0]  rem;
  logic [PW-1:0]  offset;
  logic           accept;
  logic           out_load;
  logic           cfg_wr;

  logic             ram_we;
  logic [WAW-1:0]   ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  word_ctl_t            wu_ctl;
  word_stat_t           wu_stat;
  logic [WORD_BITS-1:0] wu_word;
  logic [BW-1:0]        wu_free_bit;

  fpba_ram #(.WIDTH(WORD_BITS), .DEPTH(NUM_WORDS), .AW(WAW)) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign wu_ctl.op   = (mode_r == MODE_MARK_OCC) ? WOP_SET : WOP_CLEAR;
  assign wu_ctl.tail = (chk_idx_r == WAW'(LAST_WORD));

  fpba_word_unit #(.WORD_BITS(WORD_BITS), .LAST_BITS(LAST_BITS), .BW(BW)) u_word (
    .ctl        (wu_ctl),
    .word_i     (ram_rdata),
    .bit_i      (bit_r),
    .word_o     (wu_word),
    .free_bit_o (wu_free_bit),
    .stat       (wu_stat)
  );

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_FIRST_TRACKED_PAGE) ? base_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= 32'd0;
    end else if (cfg_wr && (cfg_paddr[2] == REG_FIRST_TRACKED_PAGE)) begin
      base_r <= cfg_pwdata;
    end
  end

  // handshakes
  assign in_req.ready = (state_r == ST_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign out_load     = (state_r == ST_DONE) && (!out_valid_r || out_res.ready);

  // datapath arithmetic
  assign diff   = {1'b0, in_req.page_id} - {1'b0, base_r};
  assign prod   = (RW+33)'(rel_r) * (RW+33)'(RECIP);
  assign qwb    = PW'(q_r) * PW'(WORD_BITS);
  assign rem    = rel_r - qwb[RW-1:0];
  assign offset = PW'(fidx_r) * PW'(WORD_BITS) + PW'(fbit_r);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    rel_nxt       = rel_r;
    inwin_nxt     = inwin_r;
    q_nxt         = q_r;
    bit_nxt       = bit_r;
    clr_addr_nxt  = clr_addr_r;
    scan_addr_nxt = scan_addr_r;
    chk_v_nxt     = chk_v_r;
    chk_idx_nxt   = chk_idx_r;
    fidx_nxt      = fidx_r;
    fbit_nxt      = fbit_r;
    res_occ_nxt   = res_occ_r;
    res_fnd_nxt   = res_fnd_r;
    res_fid_nxt   = res_fid_r;
    res_oor_nxt   = res_oor_r;
    ram_we        = 1'b0;
    ram_waddr     = q_r;
    ram_wdata     = wu_word;
    ram_raddr     = q_r;

    case (state_r)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = (clr_addr_r == '0) ? {{(WORD_BITS-1){1'b0}}, 1'b1} : '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == WAW'(LAST_WORD)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          mode_nxt      = mode_t'(in_req.mode);
          rel_nxt       = diff[RW-1:0];
          inwin_nxt     = !diff[32] && (diff[31:0] < 32'(TRACKED_PAGES));
          res_occ_nxt   = 1'b0;
          res_fnd_nxt   = 1'b0;
          res_fid_nxt   = 32'd0;
          res_oor_nxt   = 1'b0;
          scan_addr_nxt = '0;
          chk_v_nxt     = 1'b0;
          chk_idx_nxt   = '0;
          state_nxt     = (mode_t'(in_req.mode) == MODE_FIND) ? ST_SCAN : ST_DIV;
        end
      end
      ST_DIV: begin
        q_nxt     = prod[32 +: WAW];
        state_nxt = ST_READ;
      end
      ST_READ: begin
        ram_raddr = q_r;
        bit_nxt   = rem[BW-1:0];
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        case (mode_r)
          MODE_QUERY: begin
            res_occ_nxt = inwin_r && wu_stat.bit_val;
          end
          MODE_MARK_OCC, MODE_MARK_FREE: begin
            ram_we      = inwin_r;
            res_oor_nxt = !inwin_r;
          end
          default: begin
            res_occ_nxt = 1'b0;
          end
        endcase
        state_nxt = ST_DONE;
      end
      ST_SCAN: begin
        ram_raddr = scan_addr_r[WAW-1:0];
        if (chk_v_r && wu_stat.has_free) begin
          res_fnd_nxt = 1'b1;
          fidx_nxt    = chk_idx_r;
          fbit_nxt    = wu_free_bit;
          state_nxt   = ST_FIN;
        end else if (chk_v_r && (chk_idx_r == WAW'(LAST_WORD))) begin
          res_fnd_nxt = 1'b0;
          state_nxt   = ST_FIN;
        end else begin
          // one word read per cycle, checked the cycle after
          chk_v_nxt   = (scan_addr_r < (WAW+1)'(NUM_WORDS));
          chk_idx_nxt = scan_addr_r[WAW-1:0];
          if (scan_addr_r < (WAW+1)'(NUM_WORDS)) begin
            scan_addr_nxt = scan_addr_r + 1'b1;
          end
        end
      end
      ST_FIN: begin
        res_fid_nxt = res_fnd_r ? (base_r + 32'(offset)) : 32'd0;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    rel_r       <= rel_nxt;
    inwin_r     <= inwin_nxt;
    q_r         <= q_nxt;
    bit_r       <= bit_nxt;
    scan_addr_r <= scan_addr_nxt;
    chk_v_r     <= chk_v_nxt;
    chk_idx_r   <= chk_idx_nxt;
    fidx_r      <= fidx_nxt;
    fbit_r      <= fbit_nxt;
    res_occ_r   <= res_occ_nxt;
    res_fnd_r   <= res_fnd_nxt;
    res_fid_r   <= res_fid_nxt;
    res_oor_r   <= res_oor_nxt;
    if (out_load) begin
      out_occ_r <= res_occ_r;
      out_fnd_r <= res_fnd_r;
      out_fid_r <= res_fid_r;
      out_oor_r <= res_oor_r;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.occupied     = out_occ_r;
  assign out_res.found        = out_fnd_r;
  assign out_res.free_page_id = out_fid_r;
  assign out_res.out_of_range = out_oor_r;

`ifndef SYNTHESIS
  a_no_accept_in_clear : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_req.ready)
    else $error("request taken during clearing pass");

  a_write_owner : assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLEAR) || ((state_r == ST_MOD) && inwin_r))
    else $error("bitmap written outside clear or in-window mark");

  a_found_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.found) |-> (!out_res.occupied && !out_res.out_of_range))
    else $error("find result carries query or mark flags");

  a_scan_bound : assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) && chk_v_r) |-> (chk_idx_r <= WAW'(LAST_WORD)))
    else $error("scan checks a word past the bitmap");

  a_load_frees_done : assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_res.valid && (state_r == ST_IDLE))
    else $error("finished result not presented");
`endif

endmodule : free_page_bitmap_allocator

`default_nettype wire
